/* hdl/sha_pkg.sv */
package sha_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [0:7] hash_t;

  typedef struct packed {
    logic       wr_en;
    logic [5:0] wr_pos;
    logic [7:0] wr_byte;
    logic       load;
    logic       step;
    logic [5:0] rnd;
  } core_ctl_t;

  localparam logic       OP_ABSORB = 1'b0;
  localparam logic       OP_FINISH = 1'b1;

  localparam logic [5:0] LAST_POS  = 6'd63;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] LAST_RND  = 6'd63;
  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [7:0] ZERO_BYTE = 8'h00;
  localparam logic [63:0] BIT_STEP = 64'd8;
  localparam logic [2:0] LAST_IDX  = 3'd7;

  localparam hash_t INIT_HASH = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

/* hdl/sha_if.sv */
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

/* hdl/sha_core.sv */
module sha_core
  import sha_pkg::*;
(
  input  logic      clk,
  input  core_ctl_t ctl,
  input  hash_t     hash_in,
  output hash_t     wv
);

  word_t w_r [0:15];
  hash_t wv_r;

  word_t sum0, sum1, chs, maj, p1, p2, sg0, sg1, w_new;

  always_comb begin
    sum1  = rotr(wv_r[4], 6) ^ rotr(wv_r[4], 11) ^ rotr(wv_r[4], 25);
    chs   = (wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]);
    sum0  = rotr(wv_r[0], 2) ^ rotr(wv_r[0], 13) ^ rotr(wv_r[0], 22);
    maj   = (wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]);
    p1    = wv_r[7] + sum1 + chs + ROUND_K[ctl.rnd] + w_r[0];
    p2    = sum0 + maj;
    sg0   = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    sg1   = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = sg1 + w_r[9] + sg0 + w_r[0];
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      w_r[ctl.wr_pos[5:2]][{~ctl.wr_pos[1:0], 3'b000} +: 8] <= ctl.wr_byte;
    end
    if (ctl.step) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[15] <= w_new;
      wv_r[7] <= wv_r[6];
      wv_r[6] <= wv_r[5];
      wv_r[5] <= wv_r[4];
      wv_r[4] <= wv_r[3] + p1;
      wv_r[3] <= wv_r[2];
      wv_r[2] <= wv_r[1];
      wv_r[1] <= wv_r[0];
      wv_r[0] <= p1 + p2;
    end else if (ctl.load) begin
      wv_r <= hash_in;
    end
  end

  assign wv = wv_r;

endmodule

/* hdl/sha256_byte_stream_hasher.sv */
// SHA-256 hasher over a byte stream.
// The input channel carries one word per message byte (opcode absorb) or a
// finish word that closes the message. The result channel returns the digest
// as eight words, h0 first, with word_index on each and last_word on the eighth.
// An absorb word is written straight into the block buffer, except that the
// one that completes a 64-byte block keeps the block busy while the round
// unit runs. A finish word writes the padding and length one byte at a time
// and runs one or two compressions before the first digest word appears. The
// rate is set by the single round unit, which does one of the 64 rounds per
// cycle, and by the byte-wide write port of the block buffer. Input ready is
// high only while the block waits for a word. The digest words are presented
// one per cycle while the receiver is ready; a stall simply holds the current
// word, and nothing is accepted until the last digest word is taken.
// Synchronous reset loads the initial hash values and clears the byte and bit
// counts; after each digest the block returns to that same state for the next
// message.
module sha256_byte_stream_hasher
  import sha_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);

  typedef enum logic [2:0] {S_IDLE, S_ROUND, S_ADD, S_PAD, S_LEN, S_OUT} state_t;

  state_t      state_r;
  logic [5:0]  fill_r;
  logic [63:0] bits_r;
  logic [5:0]  rnd_r;
  logic [2:0]  idx_r;
  logic        pad_r;
  logic        final_r;
  hash_t       hash_r;
  hash_t       wv;
  core_ctl_t   ctl;
  logic        in_acc;
  logic        out_acc;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign in_acc             = in_ch.valid & in_ch.ready;
  assign out_ch.valid       = (state_r == S_OUT);
  assign out_acc            = out_ch.valid & out_ch.ready;
  assign out_ch.digest_word = hash_r[idx_r];
  assign out_ch.word_index  = idx_r;
  assign out_ch.last_word   = (idx_r == LAST_IDX);

  always_comb begin
    ctl        = '0;
    ctl.wr_pos = fill_r;
    ctl.rnd    = rnd_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ctl.wr_en   = 1'b1;
          ctl.wr_byte = (in_ch.opcode == OP_ABSORB) ? in_ch.data_byte : PAD_BYTE;
          ctl.load    = (fill_r == LAST_POS);
        end
      end
      S_ROUND: begin
        ctl.step = 1'b1;
      end
      S_PAD: begin
        if (fill_r != LEN_POS) begin
          ctl.wr_en   = 1'b1;
          ctl.wr_byte = ZERO_BYTE;
          ctl.load    = (fill_r == LAST_POS);
        end
      end
      S_LEN: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_byte = bits_r[{~fill_r[2:0], 3'b000} +: 8];
        ctl.load    = (fill_r == LAST_POS);
      end
      default: begin
      end
    endcase
  end

  sha_core u_core (
    .clk     (clk),
    .ctl     (ctl),
    .hash_in (hash_r),
    .wv      (wv)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      bits_r  <= '0;
      rnd_r   <= '0;
      idx_r   <= '0;
      pad_r   <= 1'b0;
      final_r <= 1'b0;
      hash_r  <= INIT_HASH;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            fill_r <= fill_r + 6'd1;
            rnd_r  <= '0;
            if (in_ch.opcode == OP_ABSORB) begin
              bits_r <= bits_r + BIT_STEP;
              if (fill_r == LAST_POS) begin
                state_r <= S_ROUND;
              end
            end else if (fill_r == LAST_POS) begin
              pad_r   <= 1'b1;
              state_r <= S_ROUND;
            end else begin
              state_r <= S_PAD;
            end
          end
        end
        S_ROUND: begin
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == LAST_RND) begin
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) begin
            hash_r[i] <= hash_r[i] + wv[i];
          end
          idx_r <= '0;
          if (final_r) begin
            state_r <= S_OUT;
          end else if (pad_r) begin
            state_r <= S_PAD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_PAD: begin
          if (fill_r == LEN_POS) begin
            state_r <= S_LEN;
          end else begin
            fill_r <= fill_r + 6'd1;
            rnd_r  <= '0;
            if (fill_r == LAST_POS) begin
              pad_r   <= 1'b1;
              state_r <= S_ROUND;
            end
          end
        end
        S_LEN: begin
          fill_r <= fill_r + 6'd1;
          rnd_r  <= '0;
          if (fill_r == LAST_POS) begin
            final_r <= 1'b1;
            state_r <= S_ROUND;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            if (idx_r == LAST_IDX) begin
              hash_r  <= INIT_HASH;
              bits_r  <= '0;
              fill_r  <= '0;
              pad_r   <= 1'b0;
              final_r <= 1'b0;
              state_r <= S_IDLE;
            end else begin
              idx_r <= idx_r + 3'd1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
